>>> sv/sprite_piece_attribute_builder_macros.svh
// ----------------------------------------------------------------------------
// Sprite piece attribute builder assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SPRITE_PIECE_ATTRIBUTE_BUILDER_MACROS_SVH
`define SPRITE_PIECE_ATTRIBUTE_BUILDER_MACROS_SVH

// Checked only while reset is released.
`define SPAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPAB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/spab_pkg.sv
// ----------------------------------------------------------------------------
// Sprite piece attribute builder package
// Request and result types, opcodes, register map and constants.
// ----------------------------------------------------------------------------
package spab_pkg;

  // Field widths fixed by the sprite table format.
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned SLOT_W  = 7;

  // Default number of hardware sprite slots.
  localparam int unsigned SPRITE_SLOTS_DEF = 80;

  // Number of scroll planes and configuration port geometry.
  localparam int unsigned PLANES  = 3;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Position mapping constants.
  localparam logic [POS_W-1:0] SCREEN_BIAS    = 16'd128;
  localparam logic [POS_W-1:0] MAP_WRAP       = 16'd2048;
  localparam logic [POS_W-1:0] WRAP_LOW_EDGE  = 16'd256;
  localparam logic [POS_W-1:0] WRAP_HIGH_EDGE = 16'd1792;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SCROLL_A_X = 3'd0;
  localparam logic [2:0] REG_SCROLL_B_X = 3'd1;
  localparam logic [2:0] REG_SCROLL_C_X = 3'd2;
  localparam logic [2:0] REG_SCROLL_A_Y = 3'd3;
  localparam logic [2:0] REG_SCROLL_B_Y = 3'd4;
  localparam logic [2:0] REG_SCROLL_C_Y = 3'd5;

  // Coordinate mode that uses the position as it is.
  localparam logic [1:0] MODE_SCREEN = 2'd0;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_PLACE = 2'd1,
    OP_BLANK = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [POS_W-1:0]   object_x;
    logic signed [POS_W-1:0]   object_y;
    logic [1:0]                coord_mode;
    logic [1:0]                object_flip;
    logic                      object_priority;
    logic signed [POS_W-1:0]   piece_x_offset;
    logic signed [POS_W-1:0]   piece_y_offset;
    logic [SIZE_W-1:0]         piece_width;
    logic [SIZE_W-1:0]         piece_height;
    logic [INDEX_W-1:0]        piece_index;
    logic [2:0]                piece_attr;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   screen_x;
    logic signed [POS_W-1:0]   screen_y;
    logic [INDEX_W-1:0]        sprite_index;
    logic [SLOT_W-1:0]         slot;
    logic                      high_priority;
    logic                      flip_h;
    logic                      flip_v;
  } res_t;

  // Scroll registers of all planes, plane one at index 0.
  typedef struct packed {
    logic [PLANES-1:0][POS_W-1:0] x;
    logic [PLANES-1:0][POS_W-1:0] y;
  } scroll_t;

endpackage

>>> sv/spab_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sprite piece attribute builder configuration registers
// APB-style register file holding the horizontal and vertical plane scrolls.
// ----------------------------------------------------------------------------
module spab_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spab_pkg::ADDR_W-1:0]        paddr,
  input  logic [spab_pkg::DATA_W-1:0]        pwdata,
  output logic [spab_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  output spab_pkg::scroll_t                  scroll_o
);

  spab_pkg::scroll_t          scroll_q, scroll_d;
  logic [2:0]                 reg_idx;
  logic                       wr_en;
  logic [spab_pkg::POS_W-1:0] rd_val;
  logic [spab_pkg::POS_W-1:0] wr_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[spab_pkg::POS_W-1:0];

  // Write decode; indexes past the last register are dropped.
  always_comb begin
    scroll_d = scroll_q;
    if (wr_en) begin
      unique case (reg_idx)
        spab_pkg::REG_SCROLL_A_X: scroll_d.x[0] = wr_val;
        spab_pkg::REG_SCROLL_B_X: scroll_d.x[1] = wr_val;
        spab_pkg::REG_SCROLL_C_X: scroll_d.x[2] = wr_val;
        spab_pkg::REG_SCROLL_A_Y: scroll_d.y[0] = wr_val;
        spab_pkg::REG_SCROLL_B_Y: scroll_d.y[1] = wr_val;
        spab_pkg::REG_SCROLL_C_Y: scroll_d.y[2] = wr_val;
        default: ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      spab_pkg::REG_SCROLL_A_X: rd_val = scroll_q.x[0];
      spab_pkg::REG_SCROLL_B_X: rd_val = scroll_q.x[1];
      spab_pkg::REG_SCROLL_C_X: rd_val = scroll_q.x[2];
      spab_pkg::REG_SCROLL_A_Y: rd_val = scroll_q.y[0];
      spab_pkg::REG_SCROLL_B_Y: rd_val = scroll_q.y[1];
      spab_pkg::REG_SCROLL_C_Y: rd_val = scroll_q.y[2];
      default:                  rd_val = '0;
    endcase
  end

  assign prdata = {{(spab_pkg::DATA_W - spab_pkg::POS_W){1'b0}}, rd_val};

  // Scroll registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_q <= '0;
    end else begin
      scroll_q <= scroll_d;
    end
  end

  assign scroll_o = scroll_q;

endmodule

>>> sv/spab_position.sv
// ----------------------------------------------------------------------------
// Sprite piece attribute builder position mapping
// Brings an object position to sprite space and applies the mirrored offset.
// ----------------------------------------------------------------------------
module spab_position (
  input  spab_pkg::req_t                    req_i,
  input  spab_pkg::scroll_t                 scroll_i,
  output logic [spab_pkg::POS_W-1:0]        screen_x_o,
  output logic [spab_pkg::POS_W-1:0]        screen_y_o
);

  logic [1:0]                 plane;
  logic [spab_pkg::POS_W-1:0] sx, sy, oy, oy_wrap;
  logic [spab_pkg::POS_W-1:0] bx, by;
  logic [spab_pkg::POS_W-1:0] w_ext, h_ext;

  // Plane one sits at index 0 for coordinate mode 1.
  assign plane = req_i.coord_mode - 2'd1;
  assign sx    = scroll_i.x[plane];
  assign sy    = scroll_i.y[plane];
  assign oy    = req_i.object_y;

  // Vertical wrap by the map height near the top or bottom edge.
  always_comb begin
    oy_wrap = oy;
    if ($signed(sy) < $signed(spab_pkg::WRAP_LOW_EDGE)) begin
      if ($signed(oy) >= $signed(spab_pkg::MAP_WRAP)) begin
        oy_wrap = oy - spab_pkg::MAP_WRAP;
      end
    end else if ($signed(sy) >= $signed(spab_pkg::WRAP_HIGH_EDGE)) begin
      if ($signed(oy) < $signed(spab_pkg::WRAP_LOW_EDGE)) begin
        oy_wrap = oy + spab_pkg::MAP_WRAP;
      end
    end
  end

  // Base position: raw screen or scrolled plane plus the screen bias.
  always_comb begin
    if (req_i.coord_mode == spab_pkg::MODE_SCREEN) begin
      bx = req_i.object_x;
      by = req_i.object_y;
    end else begin
      bx = req_i.object_x - sx + spab_pkg::SCREEN_BIAS;
      by = oy_wrap - sy + spab_pkg::SCREEN_BIAS;
    end
  end

  assign w_ext = {1'b0, req_i.piece_width};
  assign h_ext = {1'b0, req_i.piece_height};

  // A flipped object mirrors the piece offset around the piece size.
  assign screen_x_o = req_i.object_flip[0] ? (bx - req_i.piece_x_offset - w_ext)
                                           : (bx + req_i.piece_x_offset);
  assign screen_y_o = req_i.object_flip[1] ? (by - req_i.piece_y_offset - h_ext)
                                           : (by + req_i.piece_y_offset);

endmodule

>>> sv/sprite_piece_attribute_builder.sv
// ----------------------------------------------------------------------------
// Sprite piece attribute builder
// Turns sprite pieces into hardware sprite table entries, one per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Requests arrive on in_req_i under in_valid_i/in_stall_o; sprite entries leave
// on out_res_o under out_valid_o/out_stall_i. A start request clears the slot
// counter, a place request builds one entry (pieces with index 0 give none),
// and a blank request writes an empty entry in the next free slot. Once the
// counter reaches SPRITE_SLOTS, place and blank requests give no entry.
// A request is captured in the input register, and its entry then moves into
// the result register once that register is empty or being drained. One
// request is taken every cycle while the receiver does not stall. When the
// receiver stalls, the result register holds its entry and in_stall_o rises
// only once the input register is also full.
// Reset empties both registers, clears the slot counter and zeroes the scroll
// registers. The user writes the scroll registers over the APB-style port only
// while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module sprite_piece_attribute_builder #(
  parameter int unsigned SPRITE_SLOTS = spab_pkg::SPRITE_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  spab_pkg::req_t                     in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output spab_pkg::res_t                     out_res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spab_pkg::ADDR_W-1:0]        paddr,
  input  logic [spab_pkg::DATA_W-1:0]        pwdata,
  output logic [spab_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam logic [spab_pkg::SLOT_W-1:0] SlotLimit = spab_pkg::SLOT_W'(SPRITE_SLOTS);

  spab_pkg::scroll_t           scroll;
  spab_pkg::req_t              s1_req_q;
  logic                        s1_valid_q, s1_valid_d;
  logic                        out_valid_q, out_valid_d;
  spab_pkg::res_t              out_res_q, out_res_d;
  logic [spab_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic                        s2_ready, s1_adv, in_fire;
  logic                        table_full, emit, blank;
  logic [spab_pkg::POS_W-1:0]  pos_x, pos_y;

  // Configuration registers.
  spab_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .scroll_o (scroll)
  );

  // Position mapping of the registered request.
  spab_position u_pos (
    .req_i      (s1_req_q),
    .scroll_i   (scroll),
    .screen_x_o (pos_x),
    .screen_y_o (pos_y)
  );

  // Pipeline handshake: the input register moves on when the result register
  // is empty or being drained.
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s2_ready);

  assign table_full = slot_q >= SlotLimit;

  // Request decode and slot counter update.
  always_comb begin
    emit   = 1'b0;
    blank  = 1'b0;
    slot_d = slot_q;
    unique case (spab_pkg::op_e'(s1_req_q.op))
      spab_pkg::OP_START: begin
        slot_d = '0;
      end
      spab_pkg::OP_PLACE: begin
        emit = !table_full && (s1_req_q.piece_index != '0);
      end
      spab_pkg::OP_BLANK: begin
        emit  = !table_full;
        blank = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      slot_d = slot_q + 1'b1;
    end
  end

  // Result entry; a blanked slot carries only its slot number.
  always_comb begin
    out_res_d.slot = slot_q;
    if (blank) begin
      out_res_d.screen_x      = '0;
      out_res_d.screen_y      = '0;
      out_res_d.sprite_index  = '0;
      out_res_d.high_priority = 1'b0;
      out_res_d.flip_h        = 1'b0;
      out_res_d.flip_v        = 1'b0;
    end else begin
      out_res_d.screen_x      = pos_x;
      out_res_d.screen_y      = pos_y;
      out_res_d.sprite_index  = s1_req_q.piece_index;
      out_res_d.high_priority = s1_req_q.object_priority | s1_req_q.piece_attr[2];
      out_res_d.flip_h        = s1_req_q.object_flip[0] ^ s1_req_q.piece_attr[0];
      out_res_d.flip_v        = s1_req_q.object_flip[1] ^ s1_req_q.piece_attr[1];
    end
  end

  assign out_valid_d = s2_ready ? (s1_valid_q && emit) : out_valid_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        slot_q <= slot_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

>>> sv/spab_checker.sv
// ----------------------------------------------------------------------------
// Sprite piece attribute builder port checker
// Concurrent checks on the top level ports, bound to every instance.
// ----------------------------------------------------------------------------
`include "sprite_piece_attribute_builder_macros.svh"

module spab_checker #(
  parameter int unsigned SPRITE_SLOTS = spab_pkg::SPRITE_SLOTS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input spab_pkg::res_t                out_res_o
);

  localparam logic [spab_pkg::SLOT_W-1:0] SlotLimit = spab_pkg::SLOT_W'(SPRITE_SLOTS);

  // A stalled entry holds until it is taken.
  `SPAB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o), "stalled entry changed")

  // Entries never address a slot beyond the table.
  `SPAB_ASSERT(a_slot_range, out_valid_o |-> out_res_o.slot < SlotLimit, "slot beyond the sprite table")

  // An entry with index 0 is a blanked slot and carries no attributes.
  `SPAB_ASSERT(a_blank_clean, out_valid_o && out_res_o.sprite_index == '0 |-> out_res_o.screen_x == '0 && out_res_o.screen_y == '0 && !out_res_o.high_priority && !out_res_o.flip_h && !out_res_o.flip_v, "blanked slot with attributes")

  // Requests are held back only while the result side is blocked.
  `SPAB_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free result register")

  // Nothing is offered while reset is held.
  `SPAB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "output active during reset")

endmodule

bind sprite_piece_attribute_builder spab_checker #(
  .SPRITE_SLOTS (SPRITE_SLOTS)
) u_spab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
